@@ hw/rtl/tte_pkg.sv @@
package tte_pkg;

    localparam int unsigned DEFAULT_TIMER_HZ = 200;
    localparam int unsigned SECONDS_PER_MIN  = 60;
    localparam int unsigned WINDOW_LEN       = 3;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned SUM_W   = TIME_W + 2;
    localparam int unsigned TEMPO_W = 16;

    localparam logic [TEMPO_W-1:0] TEMPO_MAX = {TEMPO_W{1'b1}};

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TAP   = 1'b1;

endpackage

@@ hw/rtl/tte_divider.sv @@
module tte_divider #(
    parameter int unsigned NUM_W = 16,
    parameter int unsigned DEN_W = 34
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quotient
);

    localparam int unsigned CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    // shift in the next dividend bit, then trial subtract
    assign shifted = {r_rem, r_q[NUM_W-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign ge      = (shifted >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

@@ hw/rtl/tap_tempo_estimator.sv @@
// A start command yields no result; a tap passes through S_SUM, S_START, S_DIV and S_HOLD
// to its result, S_DIV skipped for a zero interval sum; NUM_W is the width of 180 * TIMER_HZ.
// Throughput: one item at a time; the restoring divider retires one quotient bit a cycle.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) clears the reference time, the interval window,
// the filled flag and the output valid.
module tap_tempo_estimator #(
    parameter int unsigned TIMER_HZ = tte_pkg::DEFAULT_TIMER_HZ
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_command,
    input  logic [tte_pkg::TIME_W-1:0] i_timestamp,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [tte_pkg::TEMPO_W-1:0] o_tempo_bpm
);

    localparam int unsigned NUMERATOR = tte_pkg::SECONDS_PER_MIN * tte_pkg::WINDOW_LEN
                                        * TIMER_HZ;
    localparam int unsigned NUM_W = $clog2(NUMERATOR + 1);
    localparam int unsigned EXT_W = (NUM_W > tte_pkg::TEMPO_W) ? NUM_W : tte_pkg::TEMPO_W;
    localparam int unsigned TW    = tte_pkg::TIME_W;
    localparam int unsigned SW    = tte_pkg::SUM_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_HOLD  = 3'd4;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [TW-1:0] r_prev_time;
    logic [TW-1:0] r_win [tte_pkg::WINDOW_LEN];
    logic          r_filled;
    logic [SW-1:0] r_sum;
    logic [tte_pkg::TEMPO_W-1:0] r_result;
    logic          r_out_valid;
    logic [tte_pkg::TEMPO_W-1:0] r_tempo;

    logic          in_xfer;
    logic [TW-1:0] interval;
    logic          div_start;
    logic          div_done;
    logic [NUM_W-1:0] div_quot;
    logic [EXT_W-1:0] sat_src;
    logic [tte_pkg::TEMPO_W-1:0] sat_val;
    logic          hold_go;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign interval   = i_timestamp - r_prev_time;
    assign div_start  = (r_state == S_START) && (r_sum != '0);
    assign hold_go    = (r_state == S_HOLD) && (!r_out_valid || i_out_ready);

    // zero sum gives the full numerator; both paths clamp to the field
    assign sat_src = (r_state == S_START) ? EXT_W'(NUMERATOR) : EXT_W'(div_quot);
    assign sat_val = (sat_src > EXT_W'(tte_pkg::TEMPO_MAX)) ? tte_pkg::TEMPO_MAX
                                                             : sat_src[tte_pkg::TEMPO_W-1:0];

    tte_divider #(
        .NUM_W (NUM_W),
        .DEN_W (SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (NUM_W'(NUMERATOR)),
        .i_divisor  (r_sum),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && (i_command == tte_pkg::CMD_TAP)) begin
                    n_state = S_SUM;
                end
            end
            S_SUM:   n_state = S_START;
            S_START: n_state = (r_sum == '0) ? S_HOLD : S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (hold_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev_time <= '0;
            r_filled    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < tte_pkg::WINDOW_LEN; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_prev_time <= i_timestamp;
                if (i_command == tte_pkg::CMD_START) begin
                    r_filled <= 1'b0;
                    for (int i = 0; i < tte_pkg::WINDOW_LEN; i++) begin
                        r_win[i] <= '0;
                    end
                end else if (!r_filled) begin
                    r_filled <= 1'b1;
                    for (int i = 0; i < tte_pkg::WINDOW_LEN; i++) begin
                        r_win[i] <= interval;
                    end
                end else begin
                    r_win[0] <= r_win[1];
                    r_win[1] <= r_win[2];
                    r_win[2] <= interval;
                end
            end
            if (hold_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SUM) begin
            r_sum <= SW'(r_win[0]) + SW'(r_win[1]) + SW'(r_win[2]);
        end
        if ((r_state == S_START) || ((r_state == S_DIV) && div_done)) begin
            r_result <= sat_val;
        end
        if (hold_go) begin
            r_tempo <= r_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tempo_bpm = r_tempo;

endmodule
